// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a in one cycle implies b in the next, skipped while reset is high.
`define CLC_ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error(msg);

// a in one cycle implies b in the next, checked during reset as well.
`define CLC_ASSERT_NEXT_ANY(lbl, clk, a, b, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error(msg);

`endif

// ----- rtl/clc_pkg.sv -----
// Shared constants and types of the complex convolution block.
`default_nettype none

package clc_pkg;

  localparam int MAX_TAPS   = 32;   // power of two, at least 2
  localparam int LEVELS     = $clog2(MAX_TAPS);
  localparam int NUM_TAPS_W = 6;
  localparam int IDX_W      = 5;
  localparam int SMP_W      = 16;
  localparam int PROD_W     = 2 * SMP_W + 1;
  localparam int SUM_W      = 39;

  localparam logic REQ_TAP    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] im;
    logic signed [SMP_W-1:0] re;
  } cplx_t;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic clear;
    logic capture;
  } cell_ctrl_t;

  // sideband that rides with a result through the adder tree
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

// ----- rtl/clc_cell.sv -----
// One tap cell: a history entry, a kernel tap and a registered complex product.
`default_nettype none

module clc_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  clc_pkg::cell_ctrl_t ctrl,
  input  wire                 active,
  input  wire                 tap_we,
  input  clc_pkg::cplx_t      tap_din,
  input  clc_pkg::cplx_t      hist_in,
  output clc_pkg::cplx_t      hist_out,
  output clc_pkg::prod_t      prod_re,
  output clc_pkg::prod_t      prod_im
);
  import clc_pkg::*;

  cplx_t hist;
  cplx_t tap;
  logic signed [2*SMP_W-1:0] m_rr, m_ii, m_ri, m_ir;

  always_comb begin
    m_rr = hist.re * tap.re;
    m_ii = hist.im * tap.im;
    m_ri = hist.re * tap.im;
    m_ir = hist.im * tap.re;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctrl.clear) begin
      hist <= '0;
    end else if (ctrl.shift) begin
      hist <= hist_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (tap_we) begin
      tap <= tap_din;
    end
  end

  // cells beyond the kernel length contribute zero
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      if (active) begin
        prod_re <= prod_t'(m_rr) - prod_t'(m_ii);
        prod_im <= prod_t'(m_ri) + prod_t'(m_ir);
      end else begin
        prod_re <= '0;
        prod_im <= '0;
      end
    end
  end

  assign hist_out = hist;

endmodule

`default_nettype wire

// ----- rtl/clc_add_tree.sv -----
// Registered binary adder tree over the cell products, with stall handling.
`default_nettype none

module clc_add_tree (
  input  wire            clk,
  input  wire            rst,
  input  clc_pkg::prod_t leaf_re [clc_pkg::MAX_TAPS],
  input  clc_pkg::prod_t leaf_im [clc_pkg::MAX_TAPS],
  input  clc_pkg::tag_t  in_tag,
  output logic           in_ready,
  output clc_pkg::sum_t  sum_re,
  output clc_pkg::sum_t  sum_im,
  output clc_pkg::tag_t  out_tag,
  input  wire            out_ready
);
  import clc_pkg::*;

  // heap numbering: node 1 is the root, node n adds children 2n and 2n+1
  sum_t node_re [1:MAX_TAPS-1];
  sum_t node_im [1:MAX_TAPS-1];

  logic [LEVELS-1:0] en_lvl;   // level 0 is the root
  logic [LEVELS-1:0] v_lvl;
  logic [LEVELS-1:0] l_lvl;

  always_comb begin
    en_lvl[0] = !v_lvl[0] || out_ready;
    for (int d = 1; d < LEVELS; d++) begin
      en_lvl[d] = !v_lvl[d] || en_lvl[d-1];
    end
  end

  for (genvar n = 1; n < MAX_TAPS; n++) begin : g_node
    localparam int D = $clog2(n + 1) - 1;
    sum_t a_re, b_re, a_im, b_im;
    if (2 * n >= MAX_TAPS) begin : g_leaf
      assign a_re = sum_t'(leaf_re[2*n-MAX_TAPS]);
      assign b_re = sum_t'(leaf_re[2*n+1-MAX_TAPS]);
      assign a_im = sum_t'(leaf_im[2*n-MAX_TAPS]);
      assign b_im = sum_t'(leaf_im[2*n+1-MAX_TAPS]);
    end else begin : g_inner
      assign a_re = node_re[2*n];
      assign b_re = node_re[2*n+1];
      assign a_im = node_im[2*n];
      assign b_im = node_im[2*n+1];
    end
    always_ff @(posedge clk) begin
      if (en_lvl[D]) begin
        node_re[n] <= a_re + b_re;
        node_im[n] <= a_im + b_im;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_lvl <= '0;
      l_lvl <= '0;
    end else begin
      if (en_lvl[LEVELS-1]) begin
        v_lvl[LEVELS-1] <= in_tag.valid;
        l_lvl[LEVELS-1] <= in_tag.last;
      end
      for (int d = 0; d < LEVELS - 1; d++) begin
        if (en_lvl[d]) begin
          v_lvl[d] <= v_lvl[d+1];
          l_lvl[d] <= l_lvl[d+1];
        end
      end
    end
  end

  assign in_ready      = en_lvl[LEVELS-1];
  assign sum_re        = node_re[1];
  assign sum_im        = node_im[1];
  assign out_tag.valid = v_lvl[0];
  assign out_tag.last  = l_lvl[0];

endmodule

`default_nettype wire

// ----- rtl/complex_linear_convolution_top.sv -----
// Top level of the complex linear convolution block: cell chain, tree, control.
//
//   channel  dir  tdata fields (low bit up)               tuser     tlast
//   s_*      in   tap_index[4:0] data_re[20:5]            req_type  last_sample
//                 data_im[36:21], zero fill to 40 bits
//   m_*      out  out_re[38:0] out_im[77:39], zero fill   -         last_out
//   cfg_*    in   num_taps, 6 bits, written when cfg_we   -         -
//
// Each sample enters the history chain; its result leaves through the history
// register, the product register in every cell and the 5 adder tree levels.
// Samples and tap requests stream at one per cycle while s_tready stays high. A
// last sample is followed by L-1 zero shifts (L the kernel length) and then a
// history clear, with s_tready low. Reset clears history, taps and the
// pipeline and sets num_taps to 1. An m_tready stall backs up stage by stage;
// bubbles inside the pipeline keep accepting requests.
`default_nettype none

module complex_linear_convolution_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [5:0]  cfg_wdata,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [39:0] s_tdata,   // tap_index, data_re, data_im, zero fill
  input  wire        s_tuser,   // req_type
  input  wire        s_tlast,   // last_sample
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [79:0] m_tdata,  // out_re, out_im, zero fill
  output logic       m_tlast    // last_out
);
  import clc_pkg::*;

  logic [NUM_TAPS_W-1:0] num_taps;
  logic [NUM_TAPS_W-1:0] len_eff;
  logic [NUM_TAPS_W-1:0] flush_cnt;

  // stage 0: history just shifted, products not yet taken
  logic hv, hlast;
  // stage 1: products registered in the cells
  logic pv, plast;

  logic en0, p_en, tree_ready;
  logic acc, sample, tap_wr, flush_shift;
  logic [IDX_W-1:0] tap_index;
  cplx_t in_data, shift_data;
  cell_ctrl_t ctrl;
  tag_t p_tag, o_tag;
  sum_t sum_re, sum_im;

  cplx_t hist [MAX_TAPS];
  prod_t prod_re [MAX_TAPS];
  prod_t prod_im [MAX_TAPS];

  assign tap_index  = s_tdata[IDX_W-1:0];
  assign in_data.re = s_tdata[IDX_W+SMP_W-1:IDX_W];
  assign in_data.im = s_tdata[IDX_W+2*SMP_W-1:IDX_W+SMP_W];

  // kernel length: zero acts as one, anything above the chain as the chain
  always_comb begin
    if (num_taps == '0) begin
      len_eff = NUM_TAPS_W'(1);
    end else if (num_taps > NUM_TAPS_W'(MAX_TAPS)) begin
      len_eff = NUM_TAPS_W'(MAX_TAPS);
    end else begin
      len_eff = num_taps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_taps <= NUM_TAPS_W'(1);
    end else if (cfg_we) begin
      num_taps <= cfg_wdata;
    end
  end

  // stall chain, back from the tree
  assign p_en = !pv || tree_ready;
  assign en0  = !hv || p_en;

  // no request while flushing, nor while the final result's history clears
  assign s_tready    = en0 && (flush_cnt == '0) && !(hv && hlast);
  assign acc         = s_tvalid && s_tready;
  assign sample      = acc && (s_tuser == REQ_SAMPLE);
  assign tap_wr      = acc && (s_tuser == REQ_TAP);
  assign flush_shift = en0 && (flush_cnt != '0);

  assign shift_data   = sample ? in_data : '0;
  assign ctrl.shift   = sample || flush_shift;
  assign ctrl.capture = hv && p_en;
  assign ctrl.clear   = hv && hlast && p_en;   // history read and cleared together

  always_ff @(posedge clk) begin
    if (rst) begin
      hv        <= 1'b0;
      hlast     <= 1'b0;
      pv        <= 1'b0;
      plast     <= 1'b0;
      flush_cnt <= '0;
    end else begin
      if (en0) begin
        hv    <= ctrl.shift;
        hlast <= sample ? (s_tlast && (len_eff == NUM_TAPS_W'(1)))
                        : (flush_cnt == NUM_TAPS_W'(1));
      end
      if (p_en) begin
        pv    <= hv;
        plast <= hlast;
      end
      if (sample && s_tlast) begin
        flush_cnt <= len_eff - NUM_TAPS_W'(1);
      end else if (flush_shift) begin
        flush_cnt <= flush_cnt - NUM_TAPS_W'(1);
      end
    end
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    cplx_t chain_in;
    if (k == 0) begin : g_head
      assign chain_in = shift_data;
    end else begin : g_body
      assign chain_in = hist[k-1];
    end
    clc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .active   (NUM_TAPS_W'(k) < len_eff),
      .tap_we   (tap_wr && (tap_index == IDX_W'(k))),
      .tap_din  (in_data),
      .hist_in  (chain_in),
      .hist_out (hist[k]),
      .prod_re  (prod_re[k]),
      .prod_im  (prod_im[k])
    );
  end

  assign p_tag.valid = pv;
  assign p_tag.last  = plast;

  clc_add_tree u_tree (
    .clk       (clk),
    .rst       (rst),
    .leaf_re   (prod_re),
    .leaf_im   (prod_im),
    .in_tag    (p_tag),
    .in_ready  (tree_ready),
    .sum_re    (sum_re),
    .sum_im    (sum_im),
    .out_tag   (o_tag),
    .out_ready (m_tready)
  );

  assign m_tvalid = o_tag.valid;
  assign m_tlast  = o_tag.last;
  assign m_tdata  = {2'b00, sum_im, sum_re};

endmodule

`default_nettype wire

// ----- rtl/clc_checker.sv -----
// Port-level checker for the convolution top level, with its bind.
`default_nettype none
`include "assert_macros.svh"

module clc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        s_tuser,
  input wire        s_tlast,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [79:0] m_tdata,
  input wire        m_tlast
);
  import clc_pkg::*;

  logic last_req;
  assign last_req = s_tvalid && s_tready && (s_tuser == REQ_SAMPLE) && s_tlast;

  // a pending result holds until taken
  `CLC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `CLC_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

  // flush or history clear follows every last sample
  `CLC_ASSERT_NEXT(a_flush_block, clk, rst, last_req, !s_tready, "request taken right after last sample")

  // reset empties the pipeline
  `CLC_ASSERT_NEXT_ANY(a_rst_empty, clk, rst, !m_tvalid, "result shown after reset")

  // the end flag only rides on a result
  `CLC_ASSERT_NEXT(a_last_valid, clk, rst, 1'b1, !m_tlast || m_tvalid, "last flag without result")

endmodule

bind complex_linear_convolution_top clc_checker u_clc_checker (.*);

`default_nettype wire
